### hw/rtl/pfds_pkg.sv
// shared types and constants for the pcm fractional divider search block
package pfds_pkg;

  // reset value of the system clock register, in hertz
  localparam logic [31:0] CLK_HZ_RESET = 32'd32000000;
  // starting value of the best deviation, the largest positive 32-bit value
  localparam logic [30:0] BEST_INIT    = 31'h7FFF_FFFF;
  // candidate value that never improves on the best deviation
  localparam logic [31:0] NO_CAND      = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN32       = 32'h8000_0000;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_QDIV,
    S_MUL,
    S_INIT,
    S_SEARCH,
    S_NDIV,
    S_NOTE,
    S_WRITE
  } pfds_state_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CAPQ,
    OP_MUL,
    OP_INIT,
    OP_POS,
    OP_NEG_FAST,
    OP_NEG_START,
    OP_NEG_END,
    OP_NOTE,
    OP_OUT
  } pfds_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic rate_zero;
    logic div_done;
    logic dev_zero;
    logic dev_neg;
    logic steps_done;
    logic neg_fast;
  } pfds_status_t;

endpackage

### hw/rtl/pfds_divider.sv
// iterative restoring divider, one quotient bit per cycle
module pfds_divider
  import pfds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic [31:0] remainder,
  output logic        done
);

  localparam int unsigned NBITS = 32;
  localparam int unsigned CNT_W = $clog2(NBITS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      quo_r;
  logic [31:0]      rem_r;
  logic [31:0]      dvs_r;

  logic [32:0]      shifted;
  logic             fits;
  logic [32:0]      diff;

  // trial subtraction for the current quotient bit
  always_comb begin
    shifted = {rem_r, quo_r[31]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  // control: busy flag, bit counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses after the last quotient bit
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NBITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

### hw/rtl/pfds_datapath.sv
// datapath: clock register, quotient, remainder and fractional pattern search
module pfds_datapath
  import pfds_pkg::*;
#(
  parameter int unsigned FRAC_STEPS = 16
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic [31:0]  in_req_rate,
  input  pfds_op_t     op,
  output pfds_status_t status,
  output logic [15:0]  out_int_divider,
  output logic [15:0]  out_frac_pattern,
  output logic         out_quotient_overflow
);

  localparam int unsigned STEP_W = $clog2(FRAC_STEPS + 1);

  logic [31:0]       clk_hz_r;
  logic [31:0]       rate_r;
  logic [31:0]       q_r;
  logic [31:0]       prod_r;
  logic [31:0]       r_r;
  logic [31:0]       b_r;
  logic [31:0]       f_r;
  logic [31:0]       dev_r;
  logic [31:0]       cand_r;
  logic [15:0]       fdiv_r;
  logic [STEP_W-1:0] steps_r;
  logic [30:0]       best_r;
  logic [15:0]       pattern_r;
  logic [15:0]       int_div_r;
  logic [15:0]       frac_r;
  logic              ovf_r;

  logic              div_start;
  logic [31:0]       div_dividend;
  logic [31:0]       div_divisor;
  logic [31:0]       div_quo;
  logic [31:0]       div_rem;
  logic              div_done;

  logic [31:0]       need;
  logic [31:0]       dneg;
  logic [31:0]       wstep;
  logic [31:0]       r_calc;
  logic [31:0]       fin;
  logic [31:0]       cand;
  logic [31:0]       mag;
  logic [31:0]       mmin;
  logic [47:0]       prod_full;

  // shared divider for the quotient and for long negative runs
  pfds_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // negative run terms: rate below 2^31 climbs, otherwise it descends
  always_comb begin
    need  = 32'd0 - dev_r;
    dneg  = {1'b0, dev_r[30:0]};
    wstep = 32'd0 - rate_r;
  end

  // divider operands
  always_comb begin
    div_start    = 1'b0;
    div_dividend = clk_hz_r;
    div_divisor  = in_req_rate;
    case (op)
      OP_LOAD: begin
        div_start = (in_req_rate != 32'd0);
      end
      OP_NEG_START: begin
        div_start = 1'b1;
        if (rate_r[31]) begin
          div_dividend = dneg;
          div_divisor  = wstep;
        end else begin
          div_dividend = need + rate_r - 32'd1;
          div_divisor  = rate_r;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // end value and skipped candidate of a negative run
  always_comb begin
    fin  = '0;
    cand = NO_CAND;
    if (op == OP_NEG_END) begin
      if (rate_r[31]) begin
        fin  = div_rem + SIGN32 + rate_r;
        cand = 32'd0 - (dev_r + rate_r);
      end else begin
        fin  = rate_r - 32'd1 - div_rem;
        cand = div_rem + 32'd1;
      end
    end else begin
      if (rate_r[31]) begin
        fin = dev_r + rate_r;
      end else begin
        fin = rate_r - need;
      end
    end
  end

  // remainder from the truncated divider and the deviation check
  always_comb begin
    prod_full = rate_r * q_r[15:0];
    r_calc    = clk_hz_r - prod_r;
    mag       = dev_r[31] ? (32'd0 - dev_r) : dev_r;
    mmin      = (cand_r < mag) ? cand_r : mag;
  end

  // status for the controller
  always_comb begin
    status.rate_zero  = (in_req_rate == 32'd0);
    status.div_done   = div_done;
    status.dev_zero   = (dev_r == 32'd0);
    status.dev_neg    = dev_r[31];
    status.steps_done = (steps_r == STEP_W'(FRAC_STEPS));
    status.neg_fast   = rate_r[31] ? (dneg < wstep) : (need <= rate_r);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        rate_r    <= in_req_rate;
        q_r       <= 32'hFFFF_FFFF;
        pattern_r <= '0;
      end
      OP_CAPQ: begin
        q_r <= div_quo;
      end
      OP_MUL: begin
        prod_r <= prod_full[31:0];
      end
      OP_INIT: begin
        r_r       <= r_calc;
        f_r       <= r_calc;
        dev_r     <= r_calc;
        b_r       <= rate_r;
        fdiv_r    <= 16'd1;
        steps_r   <= '0;
        best_r    <= BEST_INIT;
        pattern_r <= '0;
      end
      OP_POS: begin
        steps_r <= steps_r + 1'b1;
        fdiv_r  <= {fdiv_r[14:0], 1'b0};
        f_r     <= f_r + r_r;
        dev_r   <= b_r - f_r - r_r;
        cand_r  <= NO_CAND;
      end
      OP_NEG_FAST, OP_NEG_END: begin
        fdiv_r[0] <= 1'b1;
        dev_r     <= fin;
        b_r       <= f_r + fin;
        cand_r    <= cand;
      end
      OP_NOTE: begin
        if (mmin < {1'b0, best_r}) begin
          best_r    <= mmin[30:0];
          pattern_r <= fdiv_r;
        end
      end
      OP_OUT: begin
        int_div_r <= q_r[15:0];
        frac_r    <= pattern_r;
        ovf_r     <= (q_r[31:16] != 16'd0);
      end
      default: begin
        rate_r <= rate_r;
      end
    endcase
  end

  assign out_int_divider       = int_div_r;
  assign out_frac_pattern      = frac_r;
  assign out_quotient_overflow = ovf_r;

endmodule

### hw/rtl/pfds_ctrl.sv
// controller state machine sequencing the divide, remainder and search steps
module pfds_ctrl
  import pfds_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  pfds_status_t status,
  output pfds_op_t     op
);

  pfds_state_t state_r;
  pfds_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.rate_zero ? S_WRITE : S_QDIV;
        end
      end
      S_QDIV: begin
        if (status.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_INIT;
      end
      S_INIT: begin
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (status.dev_zero) begin
          state_nxt = S_WRITE;
        end else if (!status.dev_neg) begin
          state_nxt = status.steps_done ? S_WRITE : S_NOTE;
        end else begin
          state_nxt = status.neg_fast ? S_NOTE : S_NDIV;
        end
      end
      S_NDIV: begin
        if (status.div_done) begin
          state_nxt = S_NOTE;
        end
      end
      S_NOTE: begin
        state_nxt = S_SEARCH;
      end
      S_WRITE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath operation and input handshake
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
        end
      end
      S_QDIV: begin
        if (status.div_done) begin
          op = OP_CAPQ;
        end
      end
      S_MUL: begin
        op = OP_MUL;
      end
      S_INIT: begin
        op = OP_INIT;
      end
      S_SEARCH: begin
        if (status.dev_zero) begin
          op = OP_NONE;
        end else if (!status.dev_neg) begin
          op = status.steps_done ? OP_NONE : OP_POS;
        end else begin
          op = status.neg_fast ? OP_NEG_FAST : OP_NEG_START;
        end
      end
      S_NDIV: begin
        if (status.div_done) begin
          op = OP_NEG_END;
        end
      end
      S_NOTE: begin
        op = OP_NOTE;
      end
      S_WRITE: begin
        if (out_free) begin
          op = OP_OUT;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  // result valid flag of the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/pcm_fractional_divider_search_top.sv
// top level of the pcm fractional divider search block
//
// Usage: write the system clock frequency in hertz through cfg_wr_en and
// cfg_wr_data while no item is in flight; it resets to 32 MHz. Each item on
// the in_ channel is a requested bit rate; one result leaves on the out_
// channel with the 16-bit integer divider, the 16-bit fractional pattern and
// the quotient overflow flag.
// Sequence: a zero bit rate goes straight to the result write. Otherwise the
// quotient comes from the shared one-bit-per-cycle divider, the remainder
// from a multiply and an init step, and the search then runs positive steps
// and negative runs, a long negative run also using the divider, with at most
// 16 positive steps and 17 negative runs, before the result is written.
// Throughput: one item in flight; a new item is taken as soon as the result
// of the previous one is in the output register, even if it is not yet
// taken. If the receiver stalls, the next result waits in the search engine
// until the output register frees up.
// Reset clears the controller and the valid flag; no clearing pass is needed.
module pcm_fractional_divider_search_top
  import pfds_pkg::*;
#(
  parameter int unsigned FRAC_STEPS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_req_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_int_divider,
  output logic [15:0] out_frac_pattern,
  output logic        out_quotient_overflow
);

  pfds_op_t     op;
  pfds_status_t status;

  // sequencing
  pfds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  // arithmetic and result registers
  pfds_datapath #(
    .FRAC_STEPS (FRAC_STEPS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_req_rate           (in_req_rate),
    .op                    (op),
    .status                (status),
    .out_int_divider       (out_int_divider),
    .out_frac_pattern      (out_frac_pattern),
    .out_quotient_overflow (out_quotient_overflow)
  );

endmodule

### bench/testbench.sv
// self-checking testbench for the pcm fractional divider search block
`timescale 1ns / 1ps

module testbench;
  import pfds_pkg::*;

  localparam int FRAC_STEPS    = 16;
  localparam int STALL_LIMIT   = 6000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int SETTLE_CYCLES = 800;
  localparam int NUM_PHASES    = 8;

  // one expected divider result, with the rate that caused it
  typedef struct packed {
    logic [31:0] req_rate;
    logic [15:0] int_divider;
    logic [15:0] frac_pattern;
    logic        quotient_overflow;
  } divider_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_req_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_int_divider;
  logic [15:0] out_frac_pattern;
  logic        out_quotient_overflow;

  // bench-side copy of the clock register
  logic [31:0] sys_clock_hz = CLK_HZ_RESET;

  logic [31:0]     pending_rates[$];
  divider_result_t expected_divs[$];

  int  outstanding = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  rx_holdoff_req = 1'b0;
  int  rx_hold_left = 0;
  logic in_taken = 1'b0;
  int  idle_cycles = 0;

  int fail_count = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int overflow_seen = 0;
  int pattern_seen = 0;
  int cfg_writes = 0;

  pcm_fractional_divider_search_top #(
    .FRAC_STEPS(FRAC_STEPS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_rate          (in_req_rate),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_int_divider      (out_int_divider),
    .out_frac_pattern     (out_frac_pattern),
    .out_quotient_overflow(out_quotient_overflow)
  );

  always #6 clk = ~clk;

  // integer divider plus search for the fractional pattern of least deviation
  function automatic divider_result_t predict_divider(input logic [31:0] rate,
                                                      input logic [31:0] hz);
    divider_result_t res;
    logic [31:0] quo, rem, acc_b, acc_f, dev, best, cand, fin, neg_dev;
    logic [15:0] fdiv, pat;
    logic [63:0] need, k, w, u, t64;
    int steps;
    int step_i;
    res.req_rate = rate;
    if (rate == 32'd0) begin
      res.int_divider = 16'hFFFF;
      res.frac_pattern = 16'd0;
      res.quotient_overflow = 1'b1;
      return res;
    end
    quo = hz / rate;
    rem = hz - rate * {16'd0, quo[15:0]};
    best = {1'b0, BEST_INIT};
    pat = 16'd0;
    fdiv = 16'd1;
    acc_b = rate;
    acc_f = rem;
    dev = rem;
    steps = 0;
    for (step_i = 0; step_i < 2 * FRAC_STEPS + 4 && dev != 32'd0; step_i++) begin
      if (!dev[31]) begin
        // positive deviation: double the pattern and add one more remainder
        if (steps == FRAC_STEPS) break;
        steps++;
        fdiv = {fdiv[14:0], 1'b0};
        acc_f = acc_f + rem;
        dev = acc_b - acc_f;
        cand = dev[31] ? (32'd0 - dev) : dev;
        if (cand < best) begin
          best = cand;
          pat = fdiv;
        end
      end else begin
        // negative run, resolved in one go
        fdiv[0] = 1'b1;
        if (!rate[31]) begin
          neg_dev = 32'd0 - dev;
          need = {32'd0, neg_dev};
          k = (need + {32'd0, rate} - 64'd1) / {32'd0, rate};
          t64 = k * {32'd0, rate} - need;
          fin = t64[31:0];
          if (k >= 64'd2) begin
            t64 = need - (k - 64'd1) * {32'd0, rate};
            cand = t64[31:0];
            if (cand < best) begin
              best = cand;
              pat = fdiv;
            end
          end
        end else begin
          // rate of 2^31 or more acts as a small downward step
          w = 64'h1_0000_0000 - {32'd0, rate};
          u = {32'd0, dev};
          k = (u - {32'd0, SIGN32}) / w + 64'd1;
          t64 = u - k * w;
          fin = t64[31:0];
          if (k >= 64'd2) begin
            t64 = 64'h1_0000_0000 - (u - w);
            cand = t64[31:0];
            if (cand < best) begin
              best = cand;
              pat = fdiv;
            end
          end
        end
        dev = fin;
        acc_b = acc_f + fin;
        if (fin < best) begin
          best = fin;
          pat = fdiv;
        end
      end
    end
    res.int_divider = quo[15:0];
    res.frac_pattern = pat;
    res.quotient_overflow = (quo > 32'h0000_FFFF);
    return res;
  endfunction

  // random bit rate, weighted toward the interesting regions for this clock
  function automatic logic [31:0] random_req_rate(input logic [31:0] hz);
    int sel;
    logic [31:0] rate;
    sel = $urandom_range(99);
    if (sel < 3) begin
      rate = 32'd0;
    end else if (sel < 28) begin
      rate = $urandom;
    end else if (sel < 45) begin
      rate = hz / $urandom_range(64, 1) + $urandom_range(8) - 32'd4;
    end else if (sel < 60) begin
      rate = $urandom_range(25000000, 8000);
    end else if (sel < 70) begin
      rate = {1'b1, 31'($urandom)};
    end else if (sel < 77) begin
      rate = $urandom_range(4096, 1);
    end else if (sel < 85) begin
      rate = hz >> $urandom_range(8);
    end else begin
      rate = $urandom >> $urandom_range(31);
    end
    return rate;
  endfunction

  task automatic write_sys_clock(input logic [31:0] hz);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_all_results();
    while (outstanding != 0) @(negedge clk);
  endtask

  // register model follows every write
  always @(posedge clk) begin
    if (!rst_n) begin
      sys_clock_hz <= CLK_HZ_RESET;
    end else if (cfg_wr_en) begin
      sys_clock_hz <= cfg_wr_data;
    end
  end

  // item driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_rates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req_rate <= pending_rates.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result ready, with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_holdoff_req) begin
      rx_holdoff_req = 1'b0;
      rx_hold_left <= HOLDOFF_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accept items, predict, and check results in order
  always @(posedge clk) begin : check_results
    divider_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_divs.push_back(predict_divider(in_req_rate, sys_clock_hz));
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_quotient_overflow) overflow_seen++;
        if (out_frac_pattern != 16'd0) pattern_seen++;
        if (expected_divs.size() == 0) begin
          $error("result with no item waiting: int_divider %0d frac_pattern %0d",
                 out_int_divider, out_frac_pattern);
          fail_count++;
        end else begin
          want = expected_divs.pop_front();
          outstanding--;
          if (out_int_divider !== want.int_divider) begin
            $error("int_divider (rate %0d): expected %0d, actual %0d",
                   want.req_rate, want.int_divider, out_int_divider);
            fail_count++;
          end
          if (out_frac_pattern !== want.frac_pattern) begin
            $error("frac_pattern (rate %0d): expected %h, actual %h",
                   want.req_rate, want.frac_pattern, out_frac_pattern);
            fail_count++;
          end
          if (out_quotient_overflow !== want.quotient_overflow) begin
            $error("quotient_overflow (rate %0d): expected %0b, actual %0b",
                   want.req_rate, want.quotient_overflow, out_quotient_overflow);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || outstanding == 0 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus sequence: directed items, then random phases over clock settings
  initial begin : run_phases
    logic [31:0] directed_rates [22];
    logic [31:0] phase_clock [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int phase_send [NUM_PHASES];
    int phase_recv [NUM_PHASES];
    int p;
    int i;
    directed_rates = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'd32000000, 32'd31999999, 32'd32000001, 32'd488, 32'd489,
                       32'd16000000, 32'd3072000, 32'd1411200, 32'd2822400, 32'd44100,
                       32'd48000, 32'd1536000, 32'd1000000, 32'd3, 32'd7,
                       32'hAAAA_AAAA, 32'h5555_5555};
    phase_clock = '{32'd32000000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h8000_0000,
                    32'd49152000, 32'd0, 32'd12288000};
    phase_items = '{200, 200, 120, 200, 150, 150, 150, 130};
    phase_send  = '{0, 66, 0, 37, 0, 66, 0, 37};
    phase_recv  = '{0, 0, 66, 37, 0, 0, 66, 37};
    phase_clock[3] = $urandom | 32'd1;
    phase_clock[6] = $urandom_range(200000000, 2000000);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items at the reset clock
    foreach (directed_rates[d]) begin
      pending_rates.push_back(directed_rates[d]);
      outstanding++;
    end
    wait_all_results();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_sys_clock(phase_clock[p]);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // first phase: long receiver hold-off while items keep coming
      if (p == 0) rx_holdoff_req = 1'b1;
      for (i = 0; i < phase_items[p]; i++) begin
        pending_rates.push_back(random_req_rate(phase_clock[p]));
        outstanding++;
      end
      wait_all_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("checked %0d results for %0d bit rates over %0d clock register writes",
             results_seen, items_accepted, cfg_writes);
    $display("%0d results had quotient overflow, %0d a nonzero fractional pattern",
             overflow_seen, pattern_seen);
    if (fail_count == 0 && expected_divs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
